// ===== hw/rtl/dtcm_pkg.sv =====
// Package for the dual timer/counter block: request and register codes,
// mode byte and control byte bit positions, and the one-timer advance function.
// No dependencies.
package dtcm_pkg;

  // Request codes carried by req_type; code 3 is unused and changes nothing.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // Register select codes; 5 to 7 are unused.
  localparam logic [2:0] SEL_LOW0  = 3'd0;
  localparam logic [2:0] SEL_LOW1  = 3'd1;
  localparam logic [2:0] SEL_HIGH0 = 3'd2;
  localparam logic [2:0] SEL_HIGH1 = 3'd3;
  localparam logic [2:0] SEL_CTRL  = 3'd4;

  // Timer modes (M1:M0).
  localparam logic [1:0] MODE_13BIT  = 2'd0;
  localparam logic [1:0] MODE_16BIT  = 2'd1;
  localparam logic [1:0] MODE_RELOAD = 2'd2;
  localparam logic [1:0] MODE_SPLIT  = 2'd3;

  // Mode byte bit positions.
  localparam int unsigned TM_CT0   = 2;
  localparam int unsigned TM_GATE0 = 3;
  localparam int unsigned TM_CT1   = 6;
  localparam int unsigned TM_GATE1 = 7;

  // Control byte bit positions.
  localparam int unsigned CTL_RUN0  = 4;
  localparam int unsigned CTL_FLAG0 = 5;
  localparam int unsigned CTL_RUN1  = 6;
  localparam int unsigned CTL_FLAG1 = 7;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       ovf;
  } adv_t;

  // Advance one timer by one tick in modes 13-bit, 16-bit and auto-reload;
  // split/halt mode holds the count here.
  function automatic adv_t timer_advance(input logic [1:0] mode,
                                         input logic [7:0] lo,
                                         input logic [7:0] hi);
    adv_t       r;
    logic [5:0] v5;
    logic [8:0] v8;
    logic [8:0] vh;
    r.lo  = lo;
    r.hi  = hi;
    r.ovf = 1'b0;
    v5 = {1'b0, lo[4:0]} + 6'd1;
    v8 = {1'b0, lo} + 9'd1;
    vh = {1'b0, hi} + 9'd1;
    case (mode)
      MODE_13BIT: begin
        r.lo = {lo[7:5], v5[4:0]};
        if (v5[5]) begin
          r.hi  = vh[7:0];
          r.ovf = vh[8];
        end
      end
      MODE_16BIT: begin
        r.lo = v8[7:0];
        if (v8[8]) begin
          r.hi  = vh[7:0];
          r.ovf = vh[8];
        end
      end
      MODE_RELOAD: begin
        if (v8[8]) begin
          r.lo  = hi;
          r.ovf = 1'b1;
        end else begin
          r.lo = v8[7:0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/dual_timer_counter_modes.sv =====
// Top level of the dual 8051-style timer/counter block.
// Depends on dtcm_pkg (codes, bit positions, timer_advance).
//
// Two timers (0 and 1), each a low/high count byte pair, run in the mode set
// by the mode byte (timer_mode_we/timer_mode_wdata): 13-bit, 16-bit, 8-bit
// auto-reload, and for timer 0 a split mode where the low byte raises flag 0
// and the high byte, run by timer 1's run bit, raises flag 1; timer 1 holds
// its count in mode 3, and its own overflow does not set flag 1 while timer 0
// is split. Each input beat is a tick, a register write or a register read.
// A tick advances each timer whose run bit is set with gate and counter
// select clear. Every input beat yields exactly one output beat carrying the
// read byte (zero unless a read) and both overflow flags after the beat.
// Rate: one beat per clock. The state update is a single pass of
// incrementers and muxes from the count registers into themselves and into
// the output register; outside reset, in_ready is high whenever the output
// register is empty or being drained in the same cycle, so a beat enters
// every cycle while out_ready stays high. out_valid rises in the cycle after
// a beat is accepted. Write the mode byte only while no beat is in flight.
module dual_timer_counter_modes (
  input  logic       clk,
  input  logic       rst,
  // mode byte
  input  logic       timer_mode_we,
  input  logic [7:0] timer_mode_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [2:0] reg_select,
  input  logic [7:0] write_data,
  // output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       overflow_flag0,
  output logic       overflow_flag1
);

  // Architectural state.
  logic [7:0] timer_mode;
  logic [7:0] count_low0;
  logic [7:0] count_high0;
  logic [7:0] count_low1;
  logic [7:0] count_high1;
  logic [7:0] control_byte;

  logic [7:0] count_low0_next;
  logic [7:0] count_high0_next;
  logic [7:0] count_low1_next;
  logic [7:0] count_high1_next;
  logic [7:0] control_byte_next;
  logic [7:0] read_data_next;

  logic       accept;
  logic [1:0] mode0;
  logic [1:0] mode1;
  logic       run0;
  logic       run1;
  logic [8:0] split_lo_sum;
  logic [8:0] split_hi_sum;
  dtcm_pkg::adv_t adv0;
  dtcm_pkg::adv_t adv1;

  // Accept a beat whenever the output register is free or emptying now.
  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Decode the mode byte: a timer runs only in timer mode with gate clear.
  assign mode0 = timer_mode[1:0];
  assign mode1 = timer_mode[5:4];
  assign run0  = control_byte[dtcm_pkg::CTL_RUN0] && !timer_mode[dtcm_pkg::TM_GATE0]
                 && !timer_mode[dtcm_pkg::TM_CT0];
  assign run1  = control_byte[dtcm_pkg::CTL_RUN1] && !timer_mode[dtcm_pkg::TM_GATE1]
                 && !timer_mode[dtcm_pkg::TM_CT1];

  // Split-mode byte incrementers for timer 0, and the normal-mode advances.
  assign split_lo_sum = {1'b0, count_low0} + 9'd1;
  assign split_hi_sum = {1'b0, count_high0} + 9'd1;
  assign adv0 = dtcm_pkg::timer_advance(mode0, count_low0, count_high0);
  assign adv1 = dtcm_pkg::timer_advance(mode1, count_low1, count_high1);

  always_comb begin
    count_low0_next   = count_low0;
    count_high0_next  = count_high0;
    count_low1_next   = count_low1;
    count_high1_next  = count_high1;
    control_byte_next = control_byte;
    read_data_next    = 8'd0;
    unique case (req_type)
      dtcm_pkg::REQ_TICK: begin
        // Timer 0: split mode runs two independent 8-bit counters.
        if (mode0 == dtcm_pkg::MODE_SPLIT) begin
          if (run0) begin
            count_low0_next = split_lo_sum[7:0];
            if (split_lo_sum[8]) control_byte_next[dtcm_pkg::CTL_FLAG0] = 1'b1;
          end
          if (run1) begin
            count_high0_next = split_hi_sum[7:0];
            if (split_hi_sum[8]) control_byte_next[dtcm_pkg::CTL_FLAG1] = 1'b1;
          end
        end else if (run0) begin
          count_low0_next  = adv0.lo;
          count_high0_next = adv0.hi;
          if (adv0.ovf) control_byte_next[dtcm_pkg::CTL_FLAG0] = 1'b1;
        end
        // Timer 1: halt in mode 3; drop its flag while timer 0 is split.
        if (run1 && mode1 != dtcm_pkg::MODE_SPLIT) begin
          count_low1_next  = adv1.lo;
          count_high1_next = adv1.hi;
          if (adv1.ovf && mode0 != dtcm_pkg::MODE_SPLIT) begin
            control_byte_next[dtcm_pkg::CTL_FLAG1] = 1'b1;
          end
        end
      end
      dtcm_pkg::REQ_WRITE: begin
        unique case (reg_select)
          dtcm_pkg::SEL_LOW0:  count_low0_next   = write_data;
          dtcm_pkg::SEL_LOW1:  count_low1_next   = write_data;
          dtcm_pkg::SEL_HIGH0: count_high0_next  = write_data;
          dtcm_pkg::SEL_HIGH1: count_high1_next  = write_data;
          dtcm_pkg::SEL_CTRL:  control_byte_next = write_data;
          default: begin
          end
        endcase
      end
      dtcm_pkg::REQ_READ: begin
        unique case (reg_select)
          dtcm_pkg::SEL_LOW0:  read_data_next = count_low0;
          dtcm_pkg::SEL_LOW1:  read_data_next = count_low1;
          dtcm_pkg::SEL_HIGH0: read_data_next = count_high0;
          dtcm_pkg::SEL_HIGH1: read_data_next = count_high1;
          dtcm_pkg::SEL_CTRL:  read_data_next = control_byte;
          default:             read_data_next = 8'd0;
        endcase
      end
      default: begin
      end
    endcase
  end

  // State registers: counts and control byte advance only on an accepted beat; the mode byte loads on timer_mode_we.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode   <= 8'd0;
      count_low0   <= 8'd0;
      count_high0  <= 8'd0;
      count_low1   <= 8'd0;
      count_high1  <= 8'd0;
      control_byte <= 8'd0;
    end else begin
      if (timer_mode_we) timer_mode <= timer_mode_wdata;
      if (accept) begin
        count_low0   <= count_low0_next;
        count_high0  <= count_high0_next;
        count_low1   <= count_low1_next;
        count_high1  <= count_high1_next;
        control_byte <= control_byte_next;
      end
    end
  end

  // Output register: fill on accept, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= read_data_next;
      overflow_flag0 <= control_byte_next[dtcm_pkg::CTL_FLAG0];
      overflow_flag1 <= control_byte_next[dtcm_pkg::CTL_FLAG1];
    end
  end

  // Flags fall only through a write of the control byte; this property covers flag 0.
  a_flag0_sticky: assert property (@(posedge clk) disable iff (rst)
    control_byte[dtcm_pkg::CTL_FLAG0] &&
    !(accept && req_type == dtcm_pkg::REQ_WRITE && reg_select == dtcm_pkg::SEL_CTRL)
    |=> control_byte[dtcm_pkg::CTL_FLAG0])
    else $error("flag 0 cleared without a control byte write");

  // The flags in an output beat match the control byte it leaves behind.
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> overflow_flag0 == control_byte[dtcm_pkg::CTL_FLAG0] &&
               overflow_flag1 == control_byte[dtcm_pkg::CTL_FLAG1])
    else $error("output flags differ from control byte");

  // Only a read beat carries nonzero read data.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    accept && req_type != dtcm_pkg::REQ_READ |=> read_data == 8'd0)
    else $error("read data nonzero on a non-read beat");

  // Timer 1 holds its count on a tick while in mode 3.
  a_t1_halt: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == dtcm_pkg::REQ_TICK && mode1 == dtcm_pkg::MODE_SPLIT
    |=> $stable(count_low1) && $stable(count_high1))
    else $error("timer 1 moved in mode 3");

endmodule

// ===== dv/dual_timer_counter_modes_test.sv =====
// Self-checking testbench for the dual timer/counter block: drives tick, write and
// read beats under random gaps and output stalls, predicts each output beat.
// Depends on dtcm_pkg and the dual_timer_counter_modes RTL.
module dual_timer_counter_modes_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves unnamed: the spare request and the spare selects.
  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
  localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

  localparam int RANDOM_BEATS = 1850;
  localparam int PHASE_BEATS  = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [7:0] rd;
    logic       flag0;
    logic       flag1;
  } timer_reply_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       carry;
  } count_pair_t;

  logic       clk;
  logic       rst;
  logic       timer_mode_we;
  logic [7:0] timer_mode_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] req_type;
  logic [2:0] reg_select;
  logic [7:0] write_data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       overflow_flag0;
  logic       overflow_flag1;

  dual_timer_counter_modes dut (
    .clk              (clk),
    .rst              (rst),
    .timer_mode_we    (timer_mode_we),
    .timer_mode_wdata (timer_mode_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .reg_select       (reg_select),
    .write_data       (write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .read_data        (read_data),
    .overflow_flag0   (overflow_flag0),
    .overflow_flag1   (overflow_flag1)
  );

  // Shadow copy of the timer state, advanced once per accepted input beat and on mode writes.
  logic [7:0] mode_shadow;
  logic [7:0] low0_shadow;
  logic [7:0] high0_shadow;
  logic [7:0] low1_shadow;
  logic [7:0] high1_shadow;
  logic [7:0] ctrl_shadow;

  timer_reply_t awaited_replies[$];

  bit no_idle = 1'b0;  // both sides run back to back while set
  int beats_sent = 0;
  int random_beats = 0;
  int modes_written = 0;
  int mismatches = 0;
  int flag0_seen = 0;
  int flag1_seen = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One timer tick in 13-bit, 16-bit or auto-reload mode; the carry marks
  // an overflow. Mode 3 never reaches here for counting.
  function automatic count_pair_t next_count(input logic [1:0] mode, input logic [7:0] lo,
                                             input logic [7:0] hi);
    count_pair_t n;
    n.lo = lo;
    n.hi = hi;
    n.carry = 1'b0;
    case (mode)
      dtcm_pkg::MODE_13BIT: begin
        // only the low five bits prescale; the top three bits ride along
        n.lo[4:0] = lo[4:0] + 5'd1;
        if (lo[4:0] == 5'h1f) begin
          n.hi = hi + 8'd1;
          n.carry = (hi == 8'hff);
        end
      end
      dtcm_pkg::MODE_16BIT: begin
        n.lo = lo + 8'd1;
        if (lo == 8'hff) begin
          n.hi = hi + 8'd1;
          n.carry = (hi == 8'hff);
        end
      end
      dtcm_pkg::MODE_RELOAD: begin
        if (lo == 8'hff) begin
          n.lo = hi;
          n.carry = 1'b1;
        end else begin
          n.lo = lo + 8'd1;
        end
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  // Apply one input beat to the shadow state and return the output beat it causes.
  function automatic timer_reply_t predict_reply(input logic [1:0] req, input logic [2:0] sel,
                                                 input logic [7:0] data);
    timer_reply_t r;
    count_pair_t  n;
    logic [1:0]   m0;
    logic [1:0]   m1;
    logic         run0;
    logic         run1;
    r.rd = 8'h00;
    m0 = mode_shadow[1:0];
    m1 = mode_shadow[5:4];
    // counter select and gate both block counting entirely
    run0 = ctrl_shadow[dtcm_pkg::CTL_RUN0] && !mode_shadow[dtcm_pkg::TM_GATE0]
           && !mode_shadow[dtcm_pkg::TM_CT0];
    run1 = ctrl_shadow[dtcm_pkg::CTL_RUN1] && !mode_shadow[dtcm_pkg::TM_GATE1]
           && !mode_shadow[dtcm_pkg::TM_CT1];
    case (req)
      dtcm_pkg::REQ_TICK: begin
        if (m0 == dtcm_pkg::MODE_SPLIT) begin
          // split: low byte on run 0 raises flag 0, high byte on run 1 raises flag 1
          if (run0) begin
            if (low0_shadow == 8'hff) ctrl_shadow[dtcm_pkg::CTL_FLAG0] = 1'b1;
            low0_shadow = low0_shadow + 8'd1;
          end
          if (run1) begin
            if (high0_shadow == 8'hff) ctrl_shadow[dtcm_pkg::CTL_FLAG1] = 1'b1;
            high0_shadow = high0_shadow + 8'd1;
          end
        end else if (run0) begin
          n = next_count(m0, low0_shadow, high0_shadow);
          low0_shadow = n.lo;
          high0_shadow = n.hi;
          if (n.carry) ctrl_shadow[dtcm_pkg::CTL_FLAG0] = 1'b1;
        end
        // timer 1 halts in mode 3; its carry is lost while timer 0 is split
        if (run1 && m1 != dtcm_pkg::MODE_SPLIT) begin
          n = next_count(m1, low1_shadow, high1_shadow);
          low1_shadow = n.lo;
          high1_shadow = n.hi;
          if (n.carry && m0 != dtcm_pkg::MODE_SPLIT) ctrl_shadow[dtcm_pkg::CTL_FLAG1] = 1'b1;
        end
      end
      dtcm_pkg::REQ_WRITE: begin
        case (sel)
          dtcm_pkg::SEL_LOW0:  low0_shadow = data;
          dtcm_pkg::SEL_LOW1:  low1_shadow = data;
          dtcm_pkg::SEL_HIGH0: high0_shadow = data;
          dtcm_pkg::SEL_HIGH1: high1_shadow = data;
          dtcm_pkg::SEL_CTRL:  ctrl_shadow = data;
          default: begin
          end
        endcase
      end
      dtcm_pkg::REQ_READ: begin
        case (sel)
          dtcm_pkg::SEL_LOW0:  r.rd = low0_shadow;
          dtcm_pkg::SEL_LOW1:  r.rd = low1_shadow;
          dtcm_pkg::SEL_HIGH0: r.rd = high0_shadow;
          dtcm_pkg::SEL_HIGH1: r.rd = high1_shadow;
          dtcm_pkg::SEL_CTRL:  r.rd = ctrl_shadow;
          default:             r.rd = 8'h00;
        endcase
      end
      default: begin
      end
    endcase
    r.flag0 = ctrl_shadow[dtcm_pkg::CTL_FLAG0];
    r.flag1 = ctrl_shadow[dtcm_pkg::CTL_FLAG1];
    return r;
  endfunction

  // Track the mode byte and every accepted input beat at the rising edge;
  // queue the predicted output beat.
  always @(posedge clk) begin
    if (rst) begin
      mode_shadow = 8'h00;
      low0_shadow = 8'h00;
      high0_shadow = 8'h00;
      low1_shadow = 8'h00;
      high1_shadow = 8'h00;
      ctrl_shadow = 8'h00;
    end else begin
      if (timer_mode_we) mode_shadow = timer_mode_wdata;
      if (in_valid && in_ready)
        awaited_replies.push_back(predict_reply(req_type, reg_select, write_data));
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted output beat against the oldest prediction.
  always @(posedge clk) begin
    timer_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: output beat with nothing expected, expected none, actual %0h/%0b/%0b",
                 $time, read_data, overflow_flag0, overflow_flag1);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("read_data", want.rd, read_data);
        check_field("overflow_flag0", {7'd0, want.flag0}, {7'd0, overflow_flag0});
        check_field("overflow_flag1", {7'd0, want.flag1}, {7'd0, overflow_flag1});
        flag0_seen += int'(overflow_flag0);
        flag1_seen += int'(overflow_flag1);
      end
    end
  end

  // Stall the output side: hold ready low a random number of cycles per beat,
  // then raise it and wait for the beat to go through.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycles,
               awaited_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one input beat: idle a random gap, present the beat at the falling
  // edge, hold it until the rising edge that accepts it. Valid stays high
  // into the next call when that call draws no gap.
  task automatic send_beat(input logic [1:0] req, input logic [2:0] sel, input logic [7:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    reg_select <= sel;
    write_data <= data;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Drop valid and drain: wait until every predicted beat has come out,
  // then wait on so the block is idle.
  task automatic settle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Pulse the mode byte write for one cycle; call only after settle.
  task automatic write_mode(input logic [7:0] mode_byte);
    @(negedge clk);
    timer_mode_we <= 1'b1;
    timer_mode_wdata <= mode_byte;
    @(negedge clk);
    timer_mode_we <= 1'b0;
    modes_written++;
  endtask

  // Register map: extreme bytes written and the low byte read back, control low nibble
  // stored, spare selects and the spare request code do nothing.
  task automatic test_register_map;
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_LOW0, 8'hff);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_HIGH0, 8'h00);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_CTRL, 8'h0f);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_LOW0, 8'h00);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_CTRL, 8'hff);
    send_beat(dtcm_pkg::REQ_WRITE, SEL_SPARE_LAST, 8'haa);
    send_beat(dtcm_pkg::REQ_READ, SEL_SPARE_FIRST, 8'h55);
    send_beat(REQ_UNUSED, dtcm_pkg::SEL_CTRL, 8'hff);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_LOW1, 8'h00);
  endtask

  // Overflow in 13-bit, split and auto-reload modes, flags held across ticks and cleared by a control
  // write, split mode on timer 0 with timer 1 halted, gated/counter no-count.
  task automatic test_timer_modes;
    // reset mode byte is 13-bit for both timers; put both one tick from overflow
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_LOW0, 8'h1f);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_HIGH0, 8'hff);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_LOW1, 8'h3f);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_HIGH1, 8'hff);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_CTRL, 8'h50);
    send_beat(dtcm_pkg::REQ_TICK, dtcm_pkg::SEL_LOW0, 8'h00);
    send_beat(dtcm_pkg::REQ_TICK, dtcm_pkg::SEL_LOW0, 8'h00);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_LOW1, 8'h00);
    settle();
    // timer 0 split, timer 1 in mode 3 holds
    write_mode({2'b00, dtcm_pkg::MODE_SPLIT, 2'b00, dtcm_pkg::MODE_SPLIT});
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_CTRL, 8'h50);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_LOW0, 8'hff);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_HIGH0, 8'hff);
    send_beat(dtcm_pkg::REQ_TICK, dtcm_pkg::SEL_LOW0, 8'h00);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_LOW1, 8'h00);
    settle();
    // gate and counter select set on both timers: nothing counts
    write_mode(8'hcc);
    send_beat(dtcm_pkg::REQ_TICK, dtcm_pkg::SEL_LOW0, 8'h00);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_LOW0, 8'h00);
    settle();
    // timer 0 auto-reload from the high byte, timer 1 16-bit
    write_mode({2'b00, dtcm_pkg::MODE_16BIT, 2'b00, dtcm_pkg::MODE_RELOAD});
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_LOW0, 8'hff);
    send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_HIGH0, 8'h80);
    send_beat(dtcm_pkg::REQ_TICK, dtcm_pkg::SEL_LOW0, 8'h00);
    send_beat(dtcm_pkg::REQ_READ, dtcm_pkg::SEL_LOW0, 8'h00);
  endtask

  // Random phases, each under its own mode byte. Most traffic is preload /
  // run / read-back sequences aimed at overflows; the rest is reads and noise.
  task automatic test_random_traffic;
    int         first_beat;
    int         phase;
    int         phase_end;
    int         kind;
    logic [7:0] mode_byte;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] ctl;
    bit         timer1;
    first_beat = beats_sent;
    phase = 0;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      settle();
      if (phase == 0) begin
        mode_byte = 8'h00;
      end else if (phase == 1) begin
        mode_byte = 8'hff;
      end else begin
        mode_byte = 8'($urandom);
        // clear gate and counter select most of the time so the timers run
        if ($urandom_range(0, 3) != 0) mode_byte = mode_byte & 8'h33;
      end
      write_mode(mode_byte);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // preload one timer near its top, set run bits, tick, read back
          timer1 = 1'($urandom_range(0, 1));
          lo = 8'($urandom);
          if ($urandom_range(0, 1)) lo = 8'($urandom_range(240, 255));
          else lo[4:0] = 5'($urandom_range(26, 31));
          hi = 8'($urandom);
          if ($urandom_range(0, 3) != 0) hi = 8'($urandom_range(252, 255));
          ctl = 8'($urandom);
          ctl[dtcm_pkg::CTL_RUN0] = ($urandom_range(0, 4) != 0);
          ctl[dtcm_pkg::CTL_RUN1] = ($urandom_range(0, 4) != 0);
          send_beat(dtcm_pkg::REQ_WRITE, timer1 ? dtcm_pkg::SEL_LOW1 : dtcm_pkg::SEL_LOW0, lo);
          send_beat(dtcm_pkg::REQ_WRITE, timer1 ? dtcm_pkg::SEL_HIGH1 : dtcm_pkg::SEL_HIGH0,
                    hi);
          send_beat(dtcm_pkg::REQ_WRITE, dtcm_pkg::SEL_CTRL, ctl);
          repeat ($urandom_range(1, 48))
            send_beat(dtcm_pkg::REQ_TICK, 3'($urandom), 8'($urandom));
          repeat ($urandom_range(1, 3))
            send_beat(dtcm_pkg::REQ_READ, 3'($urandom_range(0, 4)), 8'($urandom));
        end else if (kind < 8) begin
          repeat ($urandom_range(1, 4))
            send_beat(dtcm_pkg::REQ_READ, 3'($urandom_range(0, 7)), 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6))
            send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 8'($urandom));
        end
      end
      phase++;
    end
    no_idle = 1'b0;
    random_beats = beats_sent - first_beat;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = dtcm_pkg::REQ_TICK;
    reg_select = dtcm_pkg::SEL_LOW0;
    write_data = 8'h00;
    timer_mode_we = 1'b0;
    timer_mode_wdata = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_map();
    test_timer_modes();
    test_random_traffic();
    settle();

    $display("Run covered %0d beats (%0d random) under %0d mode byte settings",
             beats_sent, random_beats, modes_written);
    $display("Flag 0 seen set in %0d output beats, flag 1 in %0d; %0d mismatches",
             flag0_seen, flag1_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== dual_timer_counter_modes.f =====
hw/rtl/dtcm_pkg.sv
hw/rtl/dual_timer_counter_modes.sv
dv/dual_timer_counter_modes_test.sv
